// File: sv/dtsa_pkg.sv
// Shared types and constants for the dual-tuner session arbiter.
package dtsa_pkg;

  typedef enum logic [2:0] {
    OP_ACQUIRE    = 3'd0,
    OP_INITIALISE = 3'd1,
    OP_UNINIT     = 3'd2,
    OP_RELEASE    = 3'd3,
    OP_DISCONNECT = 3'd4,
    OP_ROUTE      = 3'd5
  } dtsa_op_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_INVALID       = 3'd1,
    ST_BUSY          = 3'd2,
    ST_START_PENDING = 3'd3,
    ST_STOP_PENDING  = 3'd4
  } dtsa_status_t;

  typedef enum logic [2:0] {
    EV_NONE           = 3'd0,
    EV_SLAVE_ATTACHED = 3'd1,
    EV_MASTER_INIT    = 3'd2,
    EV_SLAVE_INIT     = 3'd3,
    EV_SLAVE_UNINIT   = 3'd4,
    EV_SLAVE_DETACHED = 3'd5,
    EV_SLAVE_GONE     = 3'd6,
    EV_MASTER_GONE    = 3'd7
  } dtsa_event_t;

  localparam logic [1:0] ROLE_MASTER = 2'd1;
  localparam logic [1:0] ROLE_SLAVE  = 2'd2;

  localparam logic [1:0] TUNER_NONE = 2'd0;
  localparam logic [1:0] TUNER_A    = 2'd1;
  localparam logic [1:0] TUNER_B    = 2'd2;

  localparam int          RATE_BITS = 24;
  localparam logic [23:0] RATE_6MHZ = 24'd6000000;
  localparam logic [23:0] RATE_8MHZ = 24'd8000000;

  // request fields other than the client id
  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  role;
    logic [1:0]  tuner;
    logic [23:0] rate;
  } dtsa_req_t;

  // result fields other than the client ids
  typedef struct packed {
    dtsa_status_t status;
    dtsa_event_t  ev_kind;
    logic [1:0]   ev_tuner;
    logic         found;
  } dtsa_res_t;

  typedef struct packed {
    logic master_sel;
    logic slave_sel;
    logic master_init;
    logic slave_init;
  } dtsa_flags_t;

endpackage

// File: sv/dtsa_core.sv
// Session state registers and the per-request decision logic.
module dtsa_core import dtsa_pkg::*; #(
  parameter int CLIENT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  dtsa_req_t                     req,
  input  logic signed [CLIENT_BITS-1:0] req_client,
  output dtsa_res_t                     res,
  output logic signed [CLIENT_BITS-1:0] ev_target,
  output logic signed [CLIENT_BITS-1:0] ev_source,
  output logic signed [CLIENT_BITS-1:0] route_client
);

  localparam logic signed [CLIENT_BITS-1:0] NO_CLIENT = '1;

  logic signed [CLIENT_BITS-1:0] master_client_r, master_client_nxt;
  logic signed [CLIENT_BITS-1:0] slave_client_r, slave_client_nxt;
  logic [1:0]                    master_tuner_r, master_tuner_nxt;
  logic [1:0]                    slave_tuner_r, slave_tuner_nxt;
  logic [RATE_BITS-1:0]          rate_r, rate_nxt;
  dtsa_flags_t                   flags_r, flags_nxt;

  logic is_master, is_slave, neg_id, tuner_ok, rate_ok;

  always_comb begin
    is_master = flags_r.master_sel && (master_client_r == req_client);
    is_slave  = flags_r.slave_sel && (slave_client_r == req_client);
    neg_id    = req_client[CLIENT_BITS-1];
    tuner_ok  = (req.tuner == TUNER_A) || (req.tuner == TUNER_B);
    rate_ok   = (req.rate == RATE_6MHZ) || (req.rate == RATE_8MHZ);
  end

  always_comb begin
    master_client_nxt = master_client_r;
    slave_client_nxt  = slave_client_r;
    master_tuner_nxt  = master_tuner_r;
    slave_tuner_nxt   = slave_tuner_r;
    rate_nxt          = rate_r;
    flags_nxt         = flags_r;
    res.status        = ST_INVALID;
    res.ev_kind       = EV_NONE;
    res.ev_tuner      = TUNER_NONE;
    res.found         = 1'b0;
    ev_target         = NO_CLIENT;
    ev_source         = NO_CLIENT;
    route_client      = NO_CLIENT;

    case (req.opcode)
      OP_ACQUIRE: begin
        if (neg_id || !(req.role inside {ROLE_MASTER, ROLE_SLAVE}) || !tuner_ok) begin
          res.status = ST_INVALID;
        end else if (req.role == ROLE_MASTER) begin
          if (!rate_ok) begin
            res.status = ST_INVALID;
          end else if (flags_r.master_sel) begin
            res.status = (master_client_r == req_client && master_tuner_r == req.tuner &&
                          rate_r == req.rate) ? ST_OK : ST_BUSY;
          end else if (flags_r.slave_sel ||
                       (slave_tuner_r != TUNER_NONE && slave_tuner_r == req.tuner)) begin
            res.status = ST_BUSY;
          end else begin
            res.status            = ST_OK;
            master_client_nxt     = req_client;
            master_tuner_nxt      = req.tuner;
            rate_nxt              = req.rate;
            flags_nxt.master_sel  = 1'b1;
            flags_nxt.master_init = 1'b0;
          end
        end else begin
          if (!flags_r.master_sel || master_client_r == req_client ||
              (req.rate != '0 && req.rate != rate_r)) begin
            res.status = ST_BUSY;
          end else if (req.tuner == master_tuner_r) begin
            res.status = ST_BUSY;
          end else if (flags_r.slave_sel) begin
            res.status = (slave_client_r == req_client && slave_tuner_r == req.tuner) ?
                         ST_OK : ST_BUSY;
          end else begin
            res.status           = ST_OK;
            slave_client_nxt     = req_client;
            slave_tuner_nxt      = req.tuner;
            flags_nxt.slave_sel  = 1'b1;
            flags_nxt.slave_init = 1'b0;
            res.ev_kind          = EV_SLAVE_ATTACHED;
            res.ev_tuner         = req.tuner;
            ev_target            = master_client_r;
            ev_source            = req_client;
          end
        end
      end
      OP_INITIALISE: begin
        if (neg_id) begin
          res.status = ST_INVALID;
        end else if (is_master) begin
          if (flags_r.master_init) begin
            res.status = ST_BUSY;
          end else begin
            res.status            = ST_OK;
            flags_nxt.master_init = 1'b1;
            if (flags_r.slave_sel) begin
              res.ev_kind  = EV_MASTER_INIT;
              res.ev_tuner = slave_tuner_r;
              ev_target    = slave_client_r;
              ev_source    = req_client;
            end
          end
        end else if (!is_slave) begin
          res.status = ST_INVALID;
        end else if (flags_r.slave_init) begin
          res.status = ST_BUSY;
        end else if (!flags_r.master_init) begin
          res.status = ST_START_PENDING;
        end else begin
          res.status           = ST_OK;
          flags_nxt.slave_init = 1'b1;
          res.ev_kind          = EV_SLAVE_INIT;
          res.ev_tuner         = slave_tuner_r;
          ev_target            = master_client_r;
          ev_source            = req_client;
        end
      end
      OP_UNINIT: begin
        if (neg_id) begin
          res.status = ST_INVALID;
        end else if (is_master) begin
          if (!flags_r.master_init) begin
            res.status = ST_INVALID;
          end else if (flags_r.slave_init) begin
            res.status = ST_STOP_PENDING;
          end else begin
            res.status            = ST_OK;
            flags_nxt.master_init = 1'b0;
          end
        end else if (!is_slave || !flags_r.slave_init) begin
          res.status = ST_INVALID;
        end else begin
          res.status           = ST_OK;
          flags_nxt.slave_init = 1'b0;
          res.ev_kind          = EV_SLAVE_UNINIT;
          res.ev_tuner         = slave_tuner_r;
          ev_target            = master_client_r;
          ev_source            = req_client;
        end
      end
      OP_RELEASE: begin
        if (neg_id) begin
          res.status = ST_INVALID;
        end else if (is_master) begin
          if (flags_r.master_init) begin
            res.status = ST_BUSY;
          end else if (flags_r.slave_sel) begin
            res.status = ST_STOP_PENDING;
          end else begin
            // whole session back to reset
            res.status        = ST_OK;
            master_client_nxt = NO_CLIENT;
            slave_client_nxt  = NO_CLIENT;
            master_tuner_nxt  = TUNER_NONE;
            slave_tuner_nxt   = TUNER_NONE;
            rate_nxt          = '0;
            flags_nxt         = '0;
          end
        end else if (!is_slave) begin
          res.status = ST_INVALID;
        end else if (flags_r.slave_init) begin
          res.status = ST_BUSY;
        end else begin
          res.status           = ST_OK;
          res.ev_kind          = EV_SLAVE_DETACHED;
          res.ev_tuner         = slave_tuner_r;
          ev_target            = master_client_r;
          ev_source            = req_client;
          slave_client_nxt     = NO_CLIENT;
          slave_tuner_nxt      = TUNER_NONE;
          flags_nxt.slave_sel  = 1'b0;
          flags_nxt.slave_init = 1'b0;
        end
      end
      OP_DISCONNECT: begin
        if (neg_id) begin
          res.status = ST_INVALID;
        end else begin
          res.status = ST_OK;
          if (is_slave) begin
            res.ev_kind          = EV_SLAVE_GONE;
            res.ev_tuner         = slave_tuner_r;
            ev_target            = master_client_r;
            ev_source            = req_client;
            slave_client_nxt     = NO_CLIENT;
            slave_tuner_nxt      = TUNER_NONE;
            flags_nxt.slave_sel  = 1'b0;
            flags_nxt.slave_init = 1'b0;
          end else if (is_master) begin
            if (flags_r.slave_sel) begin
              res.ev_kind  = EV_MASTER_GONE;
              res.ev_tuner = slave_tuner_r;
              ev_target    = slave_client_r;
              ev_source    = req_client;
            end
            master_client_nxt = NO_CLIENT;
            slave_client_nxt  = NO_CLIENT;
            master_tuner_nxt  = TUNER_NONE;
            slave_tuner_nxt   = TUNER_NONE;
            rate_nxt          = '0;
            flags_nxt         = '0;
          end
        end
      end
      OP_ROUTE: begin
        if (!tuner_ok) begin
          res.status = ST_INVALID;
        end else begin
          res.status = ST_OK;
          if (flags_r.master_sel && flags_r.master_init && master_tuner_r == req.tuner) begin
            route_client = master_client_r;
          end else if (flags_r.slave_sel && flags_r.slave_init &&
                       slave_tuner_r == req.tuner) begin
            route_client = slave_client_r;
          end
          res.found = !route_client[CLIENT_BITS-1];
        end
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_client_r <= NO_CLIENT;
      slave_client_r  <= NO_CLIENT;
      master_tuner_r  <= TUNER_NONE;
      slave_tuner_r   <= TUNER_NONE;
      rate_r          <= '0;
      flags_r         <= '0;
    end else if (fire) begin
      master_client_r <= master_client_nxt;
      slave_client_r  <= slave_client_nxt;
      master_tuner_r  <= master_tuner_nxt;
      slave_tuner_r   <= slave_tuner_nxt;
      rate_r          <= rate_nxt;
      flags_r         <= flags_nxt;
    end
  end

  // session invariants
  a_slave_needs_master: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.slave_sel |-> flags_r.master_sel)
    else $error("slave attached without a master");

  a_master_init_sel: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.master_init |-> flags_r.master_sel)
    else $error("master initialised but not selected");

  a_slave_init_order: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.slave_init |-> (flags_r.slave_sel && flags_r.master_init))
    else $error("slave initialised ahead of master");

  a_tuners_differ: assert property (@(posedge clk) disable iff (!rst_n)
    (flags_r.master_sel && flags_r.slave_sel) |-> (master_tuner_r != slave_tuner_r))
    else $error("both clients hold the same tuner");

endmodule

// File: sv/dual_tuner_session_arbiter.sv
// Top level of the dual-tuner session arbiter: input register, core, result register.
//
// Arbitrates a two-tuner device between one master client and one slave
// client. Each input beat is one request (acquire, initialise, uninitialise,
// release, disconnect, route) and yields exactly one result beat carrying a
// status, an optional peer notification (kind, target, source, tuner) and,
// for route, the owning client. The master fixes the shared rate (6 or 8 MHz);
// a slave attaches only at that rate (or rate 0) and on the other tuner.
// A master release or disconnect returns the session to its reset state.
// Throughput is one request per clock while out_ready allows: a request
// sits in the input register, the core decides status, event and next
// session state in combinational logic, and the answer lands in the result
// register while the session registers update in the same edge. in_ready
// stays high while the result register is free or being drained, so
// back-to-back beats flow with no bubbles; back-pressure on out_ready
// stalls the input register in turn.
module dual_tuner_session_arbiter import dtsa_pkg::*; #(
  parameter int CLIENT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_opcode,
  input  logic signed [CLIENT_BITS-1:0] in_client_id,
  input  logic [1:0]                    in_role,
  input  logic [1:0]                    in_tuner,
  input  logic [23:0]                   in_sample_rate_hz,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_status,
  output logic [2:0]                    out_event_kind,
  output logic signed [CLIENT_BITS-1:0] out_event_target,
  output logic signed [CLIENT_BITS-1:0] out_event_source,
  output logic [1:0]                    out_event_tuner,
  output logic                          out_route_found,
  output logic signed [CLIENT_BITS-1:0] out_route_client
);

  // input register
  logic                          in_vld_r;
  dtsa_req_t                     in_req_r;
  logic signed [CLIENT_BITS-1:0] in_client_r;

  // result register
  logic                          out_vld_r;
  dtsa_res_t                     out_res_r;
  logic signed [CLIENT_BITS-1:0] out_target_r, out_source_r, out_route_r;

  // core results for the request in the input register
  dtsa_res_t                     core_res;
  logic signed [CLIENT_BITS-1:0] core_target, core_source, core_route;

  // advance: input register holds a request and the result register can take it
  logic advance;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_req_r.opcode <= in_opcode;
      in_req_r.role   <= in_role;
      in_req_r.tuner  <= in_tuner;
      in_req_r.rate   <= in_sample_rate_hz;
      in_client_r     <= in_client_id;
    end
  end

  dtsa_core #(
    .CLIENT_BITS (CLIENT_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (advance),
    .req          (in_req_r),
    .req_client   (in_client_r),
    .res          (core_res),
    .ev_target    (core_target),
    .ev_source    (core_source),
    .route_client (core_route)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r    <= core_res;
      out_target_r <= core_target;
      out_source_r <= core_source;
      out_route_r  <= core_route;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = out_res_r.status;
  assign out_event_kind   = out_res_r.ev_kind;
  assign out_event_target = out_target_r;
  assign out_event_source = out_source_r;
  assign out_event_tuner  = out_res_r.ev_tuner;
  assign out_route_found  = out_res_r.found;
  assign out_route_client = out_route_r;

  // a request never overwrites an unclaimed result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |-> !advance)
    else $error("result register overwritten while stalled");

  // no event is reported without a target client
  a_event_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.ev_kind != EV_NONE) |-> !out_target_r[CLIENT_BITS-1])
    else $error("event without a valid target");

  // route_found agrees with the reported owner
  a_route_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_res_r.found == !out_route_r[CLIENT_BITS-1]))
    else $error("route_found disagrees with route_client");

endmodule

// File: sim/tb_dual_tuner_session_arbiter.sv
// Self-checking testbench for the dual-tuner session arbiter.
`timescale 1ns / 1ps

module tb_dual_tuner_session_arbiter import dtsa_pkg::*; ();

  localparam int CID_W        = 16;
  localparam int ITEMS_TOTAL  = 1775;
  localparam int PHASE_BEATS  = 160;
  localparam int LIMIT_CYCLES = 200000;
  localparam int SHOW_MAX     = 10;

  // codes outside the package enums, still legal on the bus
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [1:0] ROLE_NONE   = 2'd0;
  localparam logic [1:0] ROLE_SPARE  = 2'd3;
  localparam logic [1:0] TUNER_SPARE = 2'd3;

  localparam logic signed [CID_W-1:0] NO_CLIENT = -16'sd1;
  localparam logic signed [CID_W-1:0] MOST_NEG  = 16'sh8000;
  localparam logic signed [CID_W-1:0] MOST_POS  = 16'sh7fff;

  // one request as driven on the input channel
  typedef struct packed {
    logic [2:0]       opcode;
    logic [CID_W-1:0] client;
    logic [1:0]       role;
    logic [1:0]       tuner;
    logic [23:0]      rate;
  } tuner_req_t;

  // one answer as expected on the result channel
  typedef struct packed {
    dtsa_status_t     status;
    dtsa_event_t      ev_kind;
    logic [CID_W-1:0] ev_target;
    logic [CID_W-1:0] ev_source;
    logic [1:0]       ev_tuner;
    logic             found;
    logic [CID_W-1:0] owner;
  } session_ans_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [2:0]              in_opcode = '0;
  logic signed [CID_W-1:0] in_client_id = '0;
  logic [1:0]              in_role = '0;
  logic [1:0]              in_tuner = '0;
  logic [23:0]             in_sample_rate_hz = '0;

  logic                    out_valid;
  logic                    out_ready = 1'b1;
  logic [2:0]              out_status;
  logic [2:0]              out_event_kind;
  logic signed [CID_W-1:0] out_event_target;
  logic signed [CID_W-1:0] out_event_source;
  logic [1:0]              out_event_tuner;
  logic                    out_route_found;
  logic signed [CID_W-1:0] out_route_client;

  dual_tuner_session_arbiter #(.CLIENT_BITS(CID_W)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_client_id      (in_client_id),
    .in_role           (in_role),
    .in_tuner          (in_tuner),
    .in_sample_rate_hz (in_sample_rate_hz),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_event_kind    (out_event_kind),
    .out_event_target  (out_event_target),
    .out_event_source  (out_event_source),
    .out_event_tuner   (out_event_tuner),
    .out_route_found   (out_route_found),
    .out_route_client  (out_route_client)
  );

  always #10 clk = ~clk;

  tuner_req_t   pending_reqs[$];   // requests not yet offered
  session_ans_t awaited_answers[$]; // answers owed by the block, oldest first
  tuner_req_t   on_bus;            // request currently presented
  int           req_beats = 0;
  int           answer_beats = 0;
  int           faults = 0;
  int           cycles = 0;

  // ---------------------------------------------------------------------
  // Session predictor: private copy of the arbiter state, advanced once per
  // accepted request beat.
  // ---------------------------------------------------------------------
  logic signed [CID_W-1:0] m_client = NO_CLIENT;
  logic signed [CID_W-1:0] s_client = NO_CLIENT;
  logic [1:0]              m_tuner = TUNER_NONE;
  logic [1:0]              s_tuner = TUNER_NONE;
  logic [23:0]             shared_rate = '0;
  logic                    m_sel = 1'b0;
  logic                    s_sel = 1'b0;
  logic                    m_init = 1'b0;
  logic                    s_init = 1'b0;

  function automatic logic tuner_valid(input logic [1:0] t);
    return (t == TUNER_A) || (t == TUNER_B);
  endfunction

  function automatic session_ans_t arbitrate(input tuner_req_t r);
    session_ans_t a;
    logic signed [CID_W-1:0] c;
    logic as_master, as_slave;
    a.status    = ST_INVALID;
    a.ev_kind   = EV_NONE;
    a.ev_target = NO_CLIENT;
    a.ev_source = NO_CLIENT;
    a.ev_tuner  = TUNER_NONE;
    a.found     = 1'b0;
    a.owner     = NO_CLIENT;
    c = r.client;
    as_master = m_sel && (m_client == c);
    as_slave  = s_sel && (s_client == c);

    case (r.opcode)
      OP_ACQUIRE: begin
        if (c < 0 || !(r.role == ROLE_MASTER || r.role == ROLE_SLAVE) ||
            !tuner_valid(r.tuner)) begin
          a.status = ST_INVALID;
        end else if (r.role == ROLE_MASTER) begin
          if (r.rate != RATE_6MHZ && r.rate != RATE_8MHZ) begin
            a.status = ST_INVALID;
          end else if (m_sel) begin
            // re-acquire with identical terms is accepted as a no-op
            a.status = (m_client == c && m_tuner == r.tuner && shared_rate == r.rate) ?
                       ST_OK : ST_BUSY;
          end else if (s_sel || (s_tuner != TUNER_NONE && s_tuner == r.tuner)) begin
            a.status = ST_BUSY;
          end else begin
            m_client    = c;
            m_tuner     = r.tuner;
            shared_rate = r.rate;
            m_sel       = 1'b1;
            m_init      = 1'b0;
            a.status    = ST_OK;
          end
        end else begin
          // slave: needs a master, its own id, the shared rate or 0, the other tuner
          if (!m_sel || m_client == c || (r.rate != 0 && r.rate != shared_rate)) begin
            a.status = ST_BUSY;
          end else if (r.tuner == m_tuner) begin
            a.status = ST_BUSY;
          end else if (s_sel) begin
            a.status = (s_client == c && s_tuner == r.tuner) ? ST_OK : ST_BUSY;
          end else begin
            s_client    = c;
            s_tuner     = r.tuner;
            s_sel       = 1'b1;
            s_init      = 1'b0;
            a.status    = ST_OK;
            a.ev_kind   = EV_SLAVE_ATTACHED;
            a.ev_target = m_client;
            a.ev_source = c;
            a.ev_tuner  = r.tuner;
          end
        end
      end
      OP_INITIALISE: begin
        if (c < 0) begin
          a.status = ST_INVALID;
        end else if (as_master) begin
          if (m_init) begin
            a.status = ST_BUSY;
          end else begin
            m_init   = 1'b1;
            a.status = ST_OK;
            if (s_sel) begin
              a.ev_kind   = EV_MASTER_INIT;
              a.ev_target = s_client;
              a.ev_source = c;
              a.ev_tuner  = s_tuner;
            end
          end
        end else if (!as_slave) begin
          a.status = ST_INVALID;
        end else if (s_init) begin
          a.status = ST_BUSY;
        end else if (!m_init) begin
          a.status = ST_START_PENDING;
        end else begin
          s_init      = 1'b1;
          a.status    = ST_OK;
          a.ev_kind   = EV_SLAVE_INIT;
          a.ev_target = m_client;
          a.ev_source = c;
          a.ev_tuner  = s_tuner;
        end
      end
      OP_UNINIT: begin
        if (c < 0) begin
          a.status = ST_INVALID;
        end else if (as_master) begin
          if (!m_init) begin
            a.status = ST_INVALID;
          end else if (s_init) begin
            a.status = ST_STOP_PENDING;
          end else begin
            m_init   = 1'b0;
            a.status = ST_OK;
          end
        end else if (!as_slave || !s_init) begin
          a.status = ST_INVALID;
        end else begin
          s_init      = 1'b0;
          a.status    = ST_OK;
          a.ev_kind   = EV_SLAVE_UNINIT;
          a.ev_target = m_client;
          a.ev_source = c;
          a.ev_tuner  = s_tuner;
        end
      end
      OP_RELEASE: begin
        if (c < 0) begin
          a.status = ST_INVALID;
        end else if (as_master) begin
          if (m_init) begin
            a.status = ST_BUSY;
          end else if (s_sel) begin
            a.status = ST_STOP_PENDING;
          end else begin
            m_client = NO_CLIENT;  m_tuner = TUNER_NONE;
            shared_rate = '0;      m_sel = 1'b0;  m_init = 1'b0;
            a.status = ST_OK;
          end
        end else if (!as_slave) begin
          a.status = ST_INVALID;
        end else if (s_init) begin
          a.status = ST_BUSY;
        end else begin
          a.status    = ST_OK;
          a.ev_kind   = EV_SLAVE_DETACHED;
          a.ev_target = m_client;
          a.ev_source = c;
          a.ev_tuner  = s_tuner;
          s_client = NO_CLIENT;  s_tuner = TUNER_NONE;  s_sel = 1'b0;  s_init = 1'b0;
        end
      end
      OP_DISCONNECT: begin
        if (c < 0) begin
          a.status = ST_INVALID;
        end else begin
          // a client with no role just gets ok
          a.status = ST_OK;
          if (as_slave) begin
            a.ev_kind   = EV_SLAVE_GONE;
            a.ev_target = m_client;
            a.ev_source = c;
            a.ev_tuner  = s_tuner;
            s_client = NO_CLIENT;  s_tuner = TUNER_NONE;  s_sel = 1'b0;  s_init = 1'b0;
          end else if (as_master) begin
            if (s_sel) begin
              a.ev_kind   = EV_MASTER_GONE;
              a.ev_target = s_client;
              a.ev_source = c;
              a.ev_tuner  = s_tuner;
            end
            // master leaving tears the whole session down
            m_client = NO_CLIENT;  s_client = NO_CLIENT;
            m_tuner = TUNER_NONE;  s_tuner = TUNER_NONE;  shared_rate = '0;
            m_sel = 1'b0;  s_sel = 1'b0;  m_init = 1'b0;  s_init = 1'b0;
          end
        end
      end
      OP_ROUTE: begin
        // route ignores the client id entirely
        if (tuner_valid(r.tuner)) begin
          a.status = ST_OK;
          if (m_sel && m_init && m_tuner == r.tuner)
            a.owner = m_client;
          else if (s_sel && s_init && s_tuner == r.tuner)
            a.owner = s_client;
          a.found = ($signed(a.owner) >= 0);
        end
      end
      default: begin
        a.status = ST_INVALID;
      end
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic tuner_req_t mk(input logic [2:0] op, input logic [CID_W-1:0] c,
                                    input logic [1:0] role, input logic [1:0] t,
                                    input logic [23:0] rate);
    tuner_req_t r;
    r.opcode = op;
    r.client = c;
    r.role   = role;
    r.tuner  = t;
    r.rate   = rate;
    return r;
  endfunction

  // small pool so ids collide often; the odd wide or negative id
  function automatic logic [CID_W-1:0] pick_client();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return CID_W'($urandom_range(0, 5));
    if (p < 70) return MOST_POS;
    if (p < 85) return CID_W'($urandom_range(0, 32767));
    return CID_W'($urandom);
  endfunction

  function automatic tuner_req_t noise_req();
    if ($urandom_range(0, 1) == 0)
      return mk(3'($urandom_range(0, 7)), CID_W'($urandom), 2'($urandom_range(0, 3)),
                2'($urandom_range(0, 3)), 24'($urandom));
    return mk(3'($urandom_range(0, 7)), pick_client(), 2'($urandom_range(0, 3)),
              2'($urandom_range(0, 3)), 24'($urandom));
  endfunction

  // Non-acquire request from client c: role and rate are don't-care, so random.
  function automatic tuner_req_t op_req(input logic [2:0] op, input logic [CID_W-1:0] c);
    return mk(op, c, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 24'($urandom));
  endfunction

  // One master/slave session lifecycle with random ids, tuners and rates,
  // then lightly scrambled: skipped steps, neighbors swapped, noise mixed in.
  task automatic add_session();
    logic [CID_W-1:0] m, s;
    logic [1:0]       tm, ts, rt;
    logic [23:0]      rm, rs;
    tuner_req_t       steps[$];
    tuner_req_t       tmp;
    int               p;
    m  = pick_client();
    s  = ($urandom_range(0, 9) == 0) ? m : pick_client();
    tm = ($urandom_range(0, 1) == 0) ? TUNER_A : TUNER_B;
    ts = ($urandom_range(0, 9) == 0) ? tm : ((tm == TUNER_A) ? TUNER_B : TUNER_A);
    rm = ($urandom_range(0, 1) == 0) ? RATE_6MHZ : RATE_8MHZ;
    if ($urandom_range(0, 99) < 8) rm = 24'($urandom);
    p  = $urandom_range(0, 99);
    rs = (p < 40) ? 24'd0 : (p < 85) ? rm : 24'($urandom);
    rt = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) :
         (($urandom_range(0, 1) == 0) ? TUNER_A : TUNER_B);

    steps.push_back(mk(OP_ACQUIRE, m, ROLE_MASTER, tm, rm));
    steps.push_back(mk(OP_ACQUIRE, s, ROLE_SLAVE, ts, rs));
    steps.push_back(op_req(OP_INITIALISE, m));
    steps.push_back(op_req(OP_INITIALISE, s));
    steps.push_back(mk(OP_ROUTE, pick_client(), 2'($urandom_range(0, 3)), rt, 24'($urandom)));
    steps.push_back(op_req(OP_UNINIT, s));
    steps.push_back(op_req(OP_UNINIT, m));
    p = $urandom_range(0, 99);
    if (p < 70) begin
      steps.push_back(op_req(OP_RELEASE, s));
      steps.push_back(op_req(OP_RELEASE, m));
    end else if (p < 90) begin
      steps.push_back(op_req(OP_DISCONNECT, m));
    end else begin
      steps.push_back(op_req(OP_DISCONNECT, s));
    end
    // usually leave nothing behind for the next session
    if ($urandom_range(0, 99) < 85) begin
      steps.push_back(op_req(OP_DISCONNECT, s));
      steps.push_back(op_req(OP_DISCONNECT, m));
    end

    for (int i = 0; i + 1 < steps.size(); i++) begin
      if ($urandom_range(0, 99) < 15) begin
        tmp = steps[i];
        steps[i] = steps[i+1];
        steps[i+1] = tmp;
      end
    end

    foreach (steps[i]) begin
      p = $urandom_range(0, 99);
      if (p >= 8) pending_reqs.push_back((p < 13) ? noise_req() : steps[i]);
      if ($urandom_range(0, 99) < 8) pending_reqs.push_back(noise_req());
    end
  endtask

  // ---------------------------------------------------------------------
  // Pacing: four phases keyed off the request beat count
  //   0: no idling   1: sender idle 59%   2: receiver stalls 59%   3: both 14%
  // ---------------------------------------------------------------------
  int pace;
  int idle_pct;
  int stall_pct;
  always_comb begin
    pace = (req_beats / PHASE_BEATS) % 4;
    case (pace)
      1:       begin idle_pct = 59; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 59; end
      3:       begin idle_pct = 14; stall_pct = 14; end
      default: begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  end

  // Driver: predicts on each accepted beat, then offers the next request
  // unless it rolls an idle cycle. Valid drops only after acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        awaited_answers.push_back(arbitrate(on_bus));
        req_beats <= req_beats + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          on_bus            = pending_reqs.pop_front();
          in_opcode         <= on_bus.opcode;
          in_client_id      <= on_bus.client;
          in_role           <= on_bus.role;
          in_tuner          <= on_bus.tuner;
          in_sample_rate_hz <= on_bus.rate;
          in_valid          <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction, then
  // rolls out_ready for the next cycle.
  session_ans_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_answers.size() == 0) begin
          faults++;
          if (faults <= SHOW_MAX)
            $display("result %0d arrived with no request outstanding", answer_beats);
        end else begin
          want = awaited_answers.pop_front();
          if (out_status !== want.status || out_event_kind !== want.ev_kind ||
              out_event_target !== want.ev_target || out_event_source !== want.ev_source ||
              out_event_tuner !== want.ev_tuner || out_route_found !== want.found ||
              out_route_client !== want.owner) begin
            faults++;
            if (faults <= SHOW_MAX)
              $display("result %0d differs: exp st=%0d ev=%0d tgt=%0d src=%0d tun=%0d %0d/%0d",
                       answer_beats, want.status, want.ev_kind, $signed(want.ev_target),
                       $signed(want.ev_source), want.ev_tuner, want.found,
                       $signed(want.owner),
                       "  got st=%0d ev=%0d tgt=%0d src=%0d tun=%0d %0d/%0d",
                       out_status, out_event_kind, out_event_target, out_event_source,
                       out_event_tuner, out_route_found, out_route_client);
          end
        end
        answer_beats++;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: far beyond the slowest legal run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    // Directed opening: reset-state queries, illegal codes, then one full
    // session that walks every status and most event kinds.
    pending_reqs.push_back(mk(OP_ROUTE, MOST_NEG, ROLE_NONE, TUNER_A, 24'd0));  // no owner
    pending_reqs.push_back(mk(OP_ROUTE, 16'sd3, ROLE_NONE, TUNER_NONE, 24'd0));
    pending_reqs.push_back(mk(OP_ROUTE, 16'sd3, ROLE_SPARE, TUNER_SPARE, 24'hffffff));
    pending_reqs.push_back(mk(OP_SPARE_LO, 16'sd0, ROLE_MASTER, TUNER_A, RATE_6MHZ));
    pending_reqs.push_back(mk(OP_SPARE_HI, MOST_POS, ROLE_SPARE, TUNER_SPARE, 24'hffffff));
    pending_reqs.push_back(mk(OP_ACQUIRE, 16'sd1, ROLE_NONE, TUNER_A, RATE_6MHZ));
    pending_reqs.push_back(mk(OP_ACQUIRE, 16'sd1, ROLE_SPARE, TUNER_A, RATE_6MHZ));
    pending_reqs.push_back(mk(OP_ACQUIRE, 16'sd1, ROLE_MASTER, TUNER_NONE, RATE_6MHZ));
    pending_reqs.push_back(mk(OP_ACQUIRE, 16'sd1, ROLE_MASTER, TUNER_SPARE, RATE_6MHZ));
    pending_reqs.push_back(mk(OP_ACQUIRE, MOST_NEG, ROLE_MASTER, TUNER_A, RATE_8MHZ));
    pending_reqs.push_back(mk(OP_ACQUIRE, 16'sd1, ROLE_MASTER, TUNER_A, 24'hffffff));
    pending_reqs.push_back(mk(OP_ACQUIRE, 16'sd1, ROLE_SLAVE, TUNER_B, 24'd0)); // no master
    pending_reqs.push_back(mk(OP_ACQUIRE, 16'sd0, ROLE_MASTER, TUNER_A, RATE_8MHZ));
    pending_reqs.push_back(mk(OP_ACQUIRE, 16'sd0, ROLE_MASTER, TUNER_A, RATE_8MHZ)); // again
    pending_reqs.push_back(mk(OP_ACQUIRE, MOST_POS, ROLE_SLAVE, TUNER_A, 24'd0)); // same tuner
    pending_reqs.push_back(mk(OP_ACQUIRE, MOST_POS, ROLE_SLAVE, TUNER_B, RATE_6MHZ)); // rate
    pending_reqs.push_back(mk(OP_ACQUIRE, MOST_POS, ROLE_SLAVE, TUNER_B, 24'd0));
    pending_reqs.push_back(op_req(OP_INITIALISE, MOST_POS));  // master not started yet
    pending_reqs.push_back(op_req(OP_INITIALISE, 16'sd0));
    pending_reqs.push_back(op_req(OP_INITIALISE, MOST_POS));
    pending_reqs.push_back(mk(OP_ROUTE, MOST_NEG, ROLE_NONE, TUNER_B, 24'd0));
    pending_reqs.push_back(op_req(OP_UNINIT, 16'sd0));        // slave still running
    pending_reqs.push_back(op_req(OP_RELEASE, 16'sd0));       // master still running
    pending_reqs.push_back(op_req(OP_DISCONNECT, 16'sd5));    // holds no role
    pending_reqs.push_back(op_req(OP_DISCONNECT, 16'sd0));    // master gone, slave told

    while (pending_reqs.size() < ITEMS_TOTAL)
      add_session();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // drain: everything offered and accepted, every answer back, then settle
    while (pending_reqs.size() != 0 || in_valid)
      @(posedge clk);
    while (awaited_answers.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    faults += awaited_answers.size();
    if (faults == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
